### sv/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg
// Types and constants shared by the bicubic Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbp_pkg;

    localparam int NUM_PTS  = 16;
    localparam int NUM_CRD  = 6;
    localparam int NUM_BAS  = 4;
    localparam int PAR_W    = 17;
    localparam int CRD_W    = 32;
    localparam int WGT_W    = 31;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [PAR_W-1:0] ONE_Q16 = 17'd65536;

    localparam int CRD_X  = 0;
    localparam int CRD_Y  = 1;
    localparam int CRD_Z  = 2;
    localparam int CRD_W_ = 3;
    localparam int CRD_TU = 4;
    localparam int CRD_TV = 5;

    typedef struct packed {
        logic                    cmd;
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [31:0]      pos_z;
        logic signed [31:0]      pos_w;
        logic signed [31:0]      tex_u;
        logic signed [31:0]      tex_v;
        logic [PAR_W-1:0]        param_u;
        logic [PAR_W-1:0]        param_v;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic signed [31:0] out_tex_u;
        logic signed [31:0] out_tex_v;
    } t_out_item;

    // A control point write travelling down the pipeline.
    typedef struct packed {
        logic [3:0]                          idx;
        logic [NUM_CRD-1:0][CRD_W-1:0]       crd;
    } t_load;

    typedef logic [NUM_BAS-1:0][WGT_W-1:0] t_wvec;

endpackage

### sv/bbp_weights.sv
// ----------------------------------------------------------------------------
// bbp_weights
// Two-stage pipeline giving the four Q.30 cubic Bernstein weights of one
// Q1.16 parameter.
// ----------------------------------------------------------------------------
module bbp_weights (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [bbp_pkg::PAR_W-1:0] i_t,
    output bbp_pkg::t_wvec           o_w
);
    import bbp_pkg::*;

    logic [PAR_W-1:0]   n_t, n_s;
    logic [PAR_W-1:0]   r_t, r_s;
    logic [2*PAR_W-1:0] r_tt, r_ss, r_ts;
    logic [50:0]        b0, b1, b2, b3, p1, p2;
    logic [50:0]        rnd0, rnd1, rnd2, rnd3;
    t_wvec              r_w;

    always_comb begin
        n_t = (i_t > ONE_Q16) ? ONE_Q16 : i_t;
        n_s = ONE_Q16 - n_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= n_t;
            r_s  <= n_s;
            r_tt <= n_t * n_t;
            r_ss <= n_s * n_s;
            r_ts <= n_t * n_s;
        end
    end

    always_comb begin
        b0   = 51'(r_ss) * 51'(r_s);
        p1   = 51'(r_ts) * 51'(r_s);
        p2   = 51'(r_ts) * 51'(r_t);
        b1   = p1 + (p1 << 1);
        b2   = p2 + (p2 << 1);
        b3   = 51'(r_tt) * 51'(r_t);
        rnd0 = b0 + 51'(1 << 17);
        rnd1 = b1 + 51'(1 << 17);
        rnd2 = b2 + 51'(1 << 17);
        rnd3 = b3 + 51'(1 << 17);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= rnd0[48:18];
            r_w[1] <= rnd1[48:18];
            r_w[2] <= rnd2[48:18];
            r_w[3] <= rnd3[48:18];
        end
    end

    assign o_w = r_w;

endmodule

### sv/bicubic_bezier_patch_eval.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval
// Bicubic Bezier patch evaluator with a 16-point control grid.
// ----------------------------------------------------------------------------
// An evaluate result is registered through stages a, b, c, d, e and f and then the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register waits, so every stage advances on one shared enable.
// Loads write the control grid when they reach the product stage.
// Reset (synchronous, active low) clears the valid bits; the grid is not cleared.
module bicubic_bezier_patch_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bbp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bbp_pkg::t_out_item o_out_data
);
    import bbp_pkg::*;

    logic en;
    logic r_a_vld, r_a_eval, r_b_vld, r_b_eval, r_c_vld, r_c_eval;
    logic r_d_vld, r_e_vld, r_f_vld, r_out_vld;
    t_load r_a_ld, r_b_ld, r_c_ld, n_ld;
    t_wvec wu, wv;
    logic [WGT_W-1:0] r_c_wt [NUM_PTS];
    logic [61:0]      wprod [NUM_PTS];
    logic signed [CRD_W-1:0] r_ctrl [NUM_CRD][NUM_PTS];
    logic signed [63:0] r_d_prod [NUM_CRD][NUM_PTS];
    logic signed [65:0] r_e_row  [NUM_CRD][NUM_BAS];
    logic signed [67:0] r_f_acc  [NUM_CRD];
    logic signed [67:0] rnd [NUM_CRD];
    logic signed [37:0] quo [NUM_CRD];
    logic [NUM_CRD-1:0][CRD_W-1:0] sat;
    t_out_item r_out;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        n_ld.idx = {i_in_data.row, i_in_data.col};
        n_ld.crd[CRD_X]  = i_in_data.pos_x;
        n_ld.crd[CRD_Y]  = i_in_data.pos_y;
        n_ld.crd[CRD_Z]  = i_in_data.pos_z;
        n_ld.crd[CRD_W_] = i_in_data.pos_w;
        n_ld.crd[CRD_TU] = i_in_data.tex_u;
        n_ld.crd[CRD_TV] = i_in_data.tex_v;
    end

    bbp_weights u_wu (.i_clk(i_clk), .i_en(en), .i_t(i_in_data.param_u), .o_w(wu));
    bbp_weights u_wv (.i_clk(i_clk), .i_en(en), .i_t(i_in_data.param_v), .o_w(wv));

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_in_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld && (r_c_eval == CMD_EVAL);
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_out_vld <= r_f_vld;
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_PTS; j++) begin
            wprod[j] = 62'(wu[j/4]) * 62'(wv[j%4]) + 62'(1 << 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_eval <= i_in_data.cmd;
            r_a_ld   <= n_ld;
            r_b_eval <= r_a_eval;
            r_b_ld   <= r_a_ld;
            r_c_eval <= r_b_eval;
            r_c_ld   <= r_b_ld;
            for (int j = 0; j < NUM_PTS; j++) begin
                r_c_wt[j] <= wprod[j][60:30];
            end
        end
    end

    // The grid is written at the same stage at which evaluates read it, so
    // every evaluate sees exactly the loads that came before it.
    always_ff @(posedge i_clk) begin
        if (en && r_c_vld && (r_c_eval == CMD_LOAD)) begin
            for (int k = 0; k < NUM_CRD; k++) begin
                r_ctrl[k][r_c_ld.idx] <= r_c_ld.crd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_CRD; k++) begin
                for (int j = 0; j < NUM_PTS; j++) begin
                    r_d_prod[k][j] <= $signed({1'b0, r_c_wt[j]}) * r_ctrl[k][j];
                end
                for (int r = 0; r < NUM_BAS; r++) begin
                    r_e_row[k][r] <= 66'(r_d_prod[k][4*r])   + 66'(r_d_prod[k][4*r+1])
                                   + 66'(r_d_prod[k][4*r+2]) + 66'(r_d_prod[k][4*r+3]);
                end
                r_f_acc[k] <= 68'(r_e_row[k][0]) + 68'(r_e_row[k][1])
                            + 68'(r_e_row[k][2]) + 68'(r_e_row[k][3]);
            end
        end
    end

    // Round half up, floor by arithmetic shift, then saturate.
    always_comb begin
        for (int k = 0; k < NUM_CRD; k++) begin
            rnd[k] = r_f_acc[k] + 68'sd536870912;
            quo[k] = rnd[k][67:30];
            if (quo[k] > 38'sd2147483647) begin
                sat[k] = 32'h7FFF_FFFF;
            end else if (quo[k] < -38'sd2147483648) begin
                sat[k] = 32'h8000_0000;
            end else begin
                sat[k] = quo[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_x     <= sat[CRD_X];
            r_out.out_y     <= sat[CRD_Y];
            r_out.out_z     <= sat[CRD_Z];
            r_out.out_w     <= sat[CRD_W_];
            r_out.out_tex_u <= sat[CRD_TU];
            r_out.out_tex_v <= sat[CRD_TV];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_vld && (r_c_eval == CMD_LOAD) && !r_f_vld) |=> !r_d_vld)
        else $error("load produced a result slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_c_vld) && $stable(r_f_vld) && $stable(r_d_vld)))
        else $error("pipeline moved during a stall");

    a_out_from_f: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !r_f_vld) |=> !o_out_valid)
        else $error("result appeared without a finished sum");

endmodule

### verif/bbp_checker.sv
// ----------------------------------------------------------------------------
// bbp_checker
// Watches both channels of the patch evaluator, keeps its own copy of the
// control grid, predicts each evaluation and compares the results in order.
// ----------------------------------------------------------------------------
module bbp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bbp_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bbp_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_evals_seen,
    output int                 o_loads_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bbp_pkg::*;

    logic signed [31:0] grid [NUM_CRD][NUM_PTS];
    t_out_item          expected_points [$];

    // Four Q.30 Bernstein weights for one Q1.16 parameter.
    function automatic void bernstein(input logic [PAR_W-1:0] par,
                                      output logic [63:0] wt [NUM_BAS]);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] b [NUM_BAS];
        t = (par > ONE_Q16) ? 64'(ONE_Q16) : 64'(par);
        s = 64'd65536 - t;
        b[0] = s * s * s;
        b[1] = 64'd3 * t * s * s;
        b[2] = 64'd3 * t * t * s;
        b[3] = t * t * t;
        for (int i = 0; i < NUM_BAS; i++) wt[i] = (b[i] + 64'd131072) >> 18;
    endfunction

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] r;
        // Arithmetic shift floors, which is round half up after the bias.
        r = (acc + 64'sd536870912) >>> 30;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_out_item eval_patch(input t_in_item it);
        logic [63:0]        wu [NUM_BAS];
        logic [63:0]        wv [NUM_BAS];
        logic signed [63:0] acc [NUM_CRD];
        logic signed [63:0] w2;
        logic signed [31:0] res [NUM_CRD];
        t_out_item          o;
        bernstein(it.param_u, wu);
        bernstein(it.param_v, wv);
        for (int k = 0; k < NUM_CRD; k++) acc[k] = 0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w2 = $signed((wu[r] * wv[c] + 64'd536870912) >> 30);
                for (int k = 0; k < NUM_CRD; k++)
                    acc[k] += w2 * 64'(grid[k][r*4+c]);
            end
        end
        for (int k = 0; k < NUM_CRD; k++) res[k] = round_sat(acc[k]);
        o.out_x     = res[CRD_X];
        o.out_y     = res[CRD_Y];
        o.out_z     = res[CRD_Z];
        o.out_w     = res[CRD_W_];
        o.out_tex_u = res[CRD_TU];
        o.out_tex_v = res[CRD_TV];
        return o;
    endfunction

    task automatic report(input string fld, input logic [31:0] e, input logic [31:0] a);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, fld, e, a);
    endtask

    initial begin
        o_fail_count = 0;
        o_evals_seen = 0;
        o_loads_seen = 0;
    end

    assign o_pending = expected_points.size();

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            if (i_in_data.cmd == CMD_LOAD) begin
                grid[CRD_X][{i_in_data.row, i_in_data.col}]  = i_in_data.pos_x;
                grid[CRD_Y][{i_in_data.row, i_in_data.col}]  = i_in_data.pos_y;
                grid[CRD_Z][{i_in_data.row, i_in_data.col}]  = i_in_data.pos_z;
                grid[CRD_W_][{i_in_data.row, i_in_data.col}] = i_in_data.pos_w;
                grid[CRD_TU][{i_in_data.row, i_in_data.col}] = i_in_data.tex_u;
                grid[CRD_TV][{i_in_data.row, i_in_data.col}] = i_in_data.tex_v;
                o_loads_seen++;
            end else begin
                expected_points.insert(expected_points.size(), eval_patch(i_in_data));
            end
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%0t: result with no evaluation outstanding", $realtime);
            end else begin
                e = expected_points.pop_front();
                o_evals_seen++;
                if (e.out_x !== i_out_data.out_x) report("x", e.out_x, i_out_data.out_x);
                if (e.out_y !== i_out_data.out_y) report("y", e.out_y, i_out_data.out_y);
                if (e.out_z !== i_out_data.out_z) report("z", e.out_z, i_out_data.out_z);
                if (e.out_w !== i_out_data.out_w) report("w", e.out_w, i_out_data.out_w);
                if (e.out_tex_u !== i_out_data.out_tex_u)
                    report("tex_u", e.out_tex_u, i_out_data.out_tex_u);
                if (e.out_tex_v !== i_out_data.out_tex_v)
                    report("tex_v", e.out_tex_v, i_out_data.out_tex_v);
            end
        end
    end

endmodule

### verif/tb_bicubic_bezier_patch_eval.sv
// ----------------------------------------------------------------------------
// tb_bicubic_bezier_patch_eval
// Drives load and evaluate transactions with random gaps and output stalls,
// including one long stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bicubic_bezier_patch_eval;
    timeunit 1ns;
    timeprecision 1ps;

    import bbp_pkg::*;

    localparam int N_RANDOM    = 1600;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int  fail_count;
    int  pending;
    int  evals_seen;
    int  loads_seen;
    int  cycle_count;
    bit  long_stall;

    bicubic_bezier_patch_eval uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    bbp_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_evals_seen (evals_seen),
        .o_loads_seen (loads_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Coordinates biased towards the extremes so that saturation is reached.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PAR_W-1:0] pick_param();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q16;
            2: return PAR_W'($urandom_range(65537, 131071));
            default: return PAR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Values in unused fields are random so that every bit is exercised.
    function automatic t_in_item make_load(input logic [3:0] idx);
        t_in_item     it;
        logic [255:0] noise;
        noise      = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
        it         = noise[$bits(t_in_item)-1:0];
        it.cmd     = CMD_LOAD;
        {it.row, it.col} = idx;
        it.pos_x = pick_coord();
        it.pos_y = pick_coord();
        it.pos_z = pick_coord();
        it.pos_w = pick_coord();
        it.tex_u = pick_coord();
        it.tex_v = pick_coord();
        return it;
    endfunction

    function automatic t_in_item make_eval(input logic [PAR_W-1:0] pu,
                                           input logic [PAR_W-1:0] pv);
        t_in_item     it;
        logic [255:0] noise;
        noise      = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
        it         = noise[$bits(t_in_item)-1:0];
        it.cmd     = CMD_EVAL;
        it.param_u = pu;
        it.param_v = pv;
        return it;
    endfunction

    task automatic send(input t_in_item it, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, one long hold-off during the random phase.
    initial begin
        int w;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                long_stall = 1'b0;
            end
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        logic [PAR_W-1:0] corner [4];
        int               kind;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        long_stall = 1'b0;
        corner     = '{17'd0, 17'd65536, 17'd131071, 17'd32768};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: fill the grid, then evaluate at corners, midpoint and
        // parameters above one.
        for (int i = 0; i < NUM_PTS; i++) send(make_load(4'(i)), 1'b0);
        for (int a = 0; a < 3; a++) send(make_eval(corner[a], corner[3 - a]), 1'b0);
        send(make_eval(17'd32768, 17'd32768), 1'b0);
        send(make_eval(17'd1, 17'd65535), 1'b0);

        // Random: mostly evaluations, with loads rewriting single points.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) long_stall = 1'b1;
            kind = $urandom_range(0, 3);
            if (kind == 0) send(make_load(4'($urandom_range(0, 15))), 1'b1);
            else           send(make_eval(pick_param(), pick_param()), n % 200 > 40);
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d control point loads and %0d evaluations,", loads_seen, evals_seen);
        $display("with parameters at and beyond the ends and saturating coordinates.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
